>>> rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check, ignored while reset is asserted
`define RCP_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("rcp assertion failed");

// concurrent check that also holds across reset
`define RCP_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("rcp assertion failed");

`endif

>>> rtl/rcp_pkg.sv
`timescale 1ns / 1ps
package rcp_pkg;

    localparam logic [31:0] C_GUESS = 32'h7EEF8000;
    localparam logic [31:0] C_TWO   = 32'h40000000;
    localparam logic [31:0] C_QNAN  = 32'h7FC00000;

    localparam int C_SIG_W = 51;
    localparam int C_EXP_W = 12;

    localparam logic signed [C_EXP_W-1:0] C_LSB_MIN  = -12'sd149;
    localparam logic signed [C_EXP_W-1:0] C_EXP_BIAS = 12'sd150;

    typedef struct packed {
        logic              sgn;
        logic signed [9:0] expo;
        logic [23:0]       man;
        logic              nan;
        logic              inf;
        logic              zero;
    } t_fp;

    // unnormalized value: sig * 2^expo, plus special flags
    typedef struct packed {
        logic                      vld;
        logic                      sgn;
        logic                      nan;
        logic                      inf;
        logic [C_SIG_W-1:0]        sig;
        logic signed [C_EXP_W-1:0] expo;
    } t_unr;

    function automatic t_fp f_unpack(input logic [31:0] b);
        t_fp f;
        f.sgn  = b[31];
        f.expo = (b[30:23] == 8'd0) ? -10'sd126 :
                 $signed({2'b00, b[30:23]}) - 10'sd127;
        f.man  = {(b[30:23] != 8'd0), b[22:0]};
        f.nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
        f.inf  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
        f.zero = (b[30:0] == 31'd0);
        return f;
    endfunction

    function automatic logic [5:0] f_lzc(input logic [C_SIG_W-1:0] v);
        logic [5:0] pos;
        pos = '0;
        for (int i = 0; i < C_SIG_W; i++) begin
            if (v[i]) begin
                pos = 6'(i);
            end
        end
        return pos;
    endfunction

endpackage

>>> rtl/rcp_fmul.sv
`timescale 1ns / 1ps
module rcp_fmul import rcp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_ce,
    input  logic        i_valid,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output t_unr        o_unr
);

    t_fp   w_a;
    t_fp   w_b;
    t_unr  n_unr;
    t_unr  r_unr;
    logic [47:0] w_prod;

    always_comb begin
        w_a    = f_unpack(i_a);
        w_b    = f_unpack(i_b);
        w_prod = w_a.man * w_b.man;
        n_unr.vld  = i_valid;
        n_unr.sgn  = w_a.sgn ^ w_b.sgn;
        n_unr.nan  = w_a.nan || w_b.nan || (w_a.inf && w_b.zero) || (w_b.inf && w_a.zero);
        n_unr.inf  = w_a.inf || w_b.inf;
        n_unr.sig  = {3'b000, w_prod};
        // each operand is man * 2^(expo-23)
        n_unr.expo = {{2{w_a.expo[9]}}, w_a.expo} + {{2{w_b.expo[9]}}, w_b.expo}
                     - 12'sd46;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unr.vld <= 1'b0;
        end else if (i_ce) begin
            r_unr.vld <= n_unr.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_unr.sgn  <= n_unr.sgn;
            r_unr.nan  <= n_unr.nan;
            r_unr.inf  <= n_unr.inf;
            r_unr.sig  <= n_unr.sig;
            r_unr.expo <= n_unr.expo;
        end
    end

    assign o_unr = r_unr;

endmodule

>>> rtl/rcp_fsub.sv
`timescale 1ns / 1ps
module rcp_fsub import rcp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_ce,
    input  logic        i_valid,
    input  logic [31:0] i_p,
    output t_unr        o_unr
);

    t_fp   w_a;
    t_fp   w_b;
    logic  w_sb;
    logic  w_b_big;
    logic signed [9:0] w_diff;
    logic [5:0]  w_dsh;
    logic [49:0] w_big;
    logic [49:0] w_small;
    logic [99:0] w_ext;
    logic [49:0] w_al;
    logic [50:0] w_sum;
    logic        w_sgn_big;
    logic signed [9:0] w_ebig;
    t_unr  n_unr;
    t_unr  r_unr;

    // computes 2.0 - p
    always_comb begin
        w_a     = f_unpack(C_TWO);
        w_b     = f_unpack(i_p);
        w_sb    = ~w_b.sgn;
        w_b_big = (w_b.expo > w_a.expo) ||
                  ((w_b.expo == w_a.expo) && (w_b.man > w_a.man));
        w_diff  = w_b_big ? (w_b.expo - w_a.expo) : (w_a.expo - w_b.expo);
        w_dsh   = (w_diff > 10'sd63) ? 6'd63 : w_diff[5:0];
        w_big   = w_b_big ? {w_b.man, 26'd0} : {w_a.man, 26'd0};
        w_small = w_b_big ? {w_a.man, 26'd0} : {w_b.man, 26'd0};
        w_sgn_big = w_b_big ? w_sb : w_a.sgn;
        w_ebig  = w_b_big ? w_b.expo : w_a.expo;
        w_ext   = {w_small, 50'd0} >> w_dsh;
        // shifted-out bits fold into a sticky lsb
        w_al    = w_ext[99:50] | {49'd0, |w_ext[49:0]};
        if (w_sb == w_a.sgn) begin
            w_sum = {1'b0, w_big} + {1'b0, w_al};
        end else begin
            w_sum = {1'b0, w_big} - {1'b0, w_al};
        end
        n_unr.vld  = i_valid;
        n_unr.nan  = w_b.nan;
        n_unr.inf  = w_b.inf;
        if (w_b.inf) begin
            n_unr.sgn = w_sb;
        end else if (w_sum == 51'd0) begin
            n_unr.sgn = 1'b0;
        end else begin
            n_unr.sgn = w_sgn_big;
        end
        n_unr.sig  = w_sum;
        n_unr.expo = {{2{w_ebig[9]}}, w_ebig} - 12'sd49;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unr.vld <= 1'b0;
        end else if (i_ce) begin
            r_unr.vld <= n_unr.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_unr.sgn  <= n_unr.sgn;
            r_unr.nan  <= n_unr.nan;
            r_unr.inf  <= n_unr.inf;
            r_unr.sig  <= n_unr.sig;
            r_unr.expo <= n_unr.expo;
        end
    end

    assign o_unr = r_unr;

endmodule

>>> rtl/rcp_norm.sv
`timescale 1ns / 1ps
module rcp_norm import rcp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_ce,
    input  t_unr        i_unr,
    output logic        o_valid,
    output logic [31:0] o_bits
);

    // stage a: leading one search and shift planning
    logic [5:0]                w_lzc;
    logic signed [C_EXP_W-1:0] w_lsb;
    logic signed [C_EXP_W-1:0] w_sh;
    logic [C_EXP_W-1:0]        w_nsh;
    logic [5:0]                w_shr;
    logic [5:0]                w_shl;

    logic                      r_vld_a;
    logic                      r_sgn_a;
    logic                      r_nan_a;
    logic                      r_inf_a;
    logic                      r_zero_a;
    logic [C_SIG_W-1:0]        r_sig_a;
    logic signed [C_EXP_W-1:0] r_lsb_a;
    logic [5:0]                r_shr_a;
    logic [5:0]                r_shl_a;

    always_comb begin
        w_lzc = f_lzc(i_unr.sig);
        w_lsb = i_unr.expo + $signed({6'd0, w_lzc}) - 12'sd23;
        if (w_lsb < C_LSB_MIN) begin
            w_lsb = C_LSB_MIN;
        end
        w_sh  = w_lsb - i_unr.expo;
        w_nsh = -w_sh;
        w_shr = 6'd0;
        w_shl = 6'd0;
        if (w_sh < 12'sd0) begin
            w_shl = w_nsh[5:0];
        end else if (w_sh > 12'sd63) begin
            w_shr = 6'd63;
        end else begin
            w_shr = w_sh[5:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
        end else if (i_ce) begin
            r_vld_a <= i_unr.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_sgn_a  <= i_unr.sgn;
            r_nan_a  <= i_unr.nan;
            r_inf_a  <= i_unr.inf;
            r_zero_a <= (i_unr.sig == '0);
            r_sig_a  <= i_unr.sig;
            r_lsb_a  <= w_lsb;
            r_shr_a  <= w_shr;
            r_shl_a  <= w_shl;
        end
    end

    // stage b: shift, round to nearest even, pack
    logic [2*C_SIG_W-1:0]      w_ext;
    logic [C_SIG_W-1:0]        w_kept;
    logic                      w_guard;
    logic                      w_sticky;
    logic                      w_up;
    logic [24:0]               w_man25;
    logic [23:0]               w_man;
    logic signed [C_EXP_W-1:0] w_lsb_f;
    logic signed [C_EXP_W-1:0] w_ef;
    logic [31:0]               n_bits;
    logic                      r_vld_b;
    logic [31:0]               r_bits_b;

    always_comb begin
        w_ext    = {C_SIG_W'(r_sig_a << r_shl_a), {C_SIG_W{1'b0}}} >> r_shr_a;
        w_kept   = w_ext[2*C_SIG_W-1:C_SIG_W];
        w_guard  = w_ext[C_SIG_W-1];
        w_sticky = |w_ext[C_SIG_W-2:0];
        w_up     = w_guard && (w_sticky || w_kept[0]);
        w_man25  = {1'b0, w_kept[23:0]} + {24'd0, w_up};
        if (w_man25[24]) begin
            w_man   = w_man25[24:1];
            w_lsb_f = r_lsb_a + 12'sd1;
        end else begin
            w_man   = w_man25[23:0];
            w_lsb_f = r_lsb_a;
        end
        w_ef = w_lsb_f + C_EXP_BIAS;
        if (r_nan_a) begin
            n_bits = C_QNAN;
        end else if (r_inf_a) begin
            n_bits = {r_sgn_a, 8'hFF, 23'd0};
        end else if (r_zero_a) begin
            n_bits = {r_sgn_a, 31'd0};
        end else if (!w_man[23]) begin
            n_bits = {r_sgn_a, 8'd0, w_man[22:0]};
        end else if (w_ef >= 12'sd255) begin
            n_bits = {r_sgn_a, 8'hFF, 23'd0};
        end else begin
            n_bits = {r_sgn_a, w_ef[7:0], w_man[22:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_b <= 1'b0;
        end else if (i_ce) begin
            r_vld_b <= r_vld_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_bits_b <= n_bits;
        end
    end

    assign o_valid = r_vld_b;
    assign o_bits  = r_bits_b;

endmodule

>>> rtl/float_reciprocal_approx_unit.sv
`timescale 1ns / 1ps
// Approximate binary32 reciprocal: guess = 0x7EEF8000 - x (integer subtract),
// then one Newton-Raphson step r = g * (2 - x * g), all binary32 with
// round-to-nearest-even and subnormals kept. NaN results come out as 0x7FC00000.
// Input channel: i_valid / i_divisor_bits, with o_stall back to the sender.
// Output channel: o_valid / o_reciprocal_bits, with i_stall from the receiver.
// A transaction happens on a rising edge with valid high and stall low.
// The datapath is three binary32 operations (multiply, subtract,
// multiply), each one operand stage followed by a two-stage normalize/round.
// One transaction per cycle unless stalled; there is no state between items.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and o_stall rises in the same cycle, so nothing is dropped or repeated.
// Synchronous active-low reset clears all valid bits; the pipeline is empty
// and ready in the first cycle after reset.
module float_reciprocal_approx_unit import rcp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_divisor_bits,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_reciprocal_bits
);

    logic        w_ce;
    logic [31:0] w_guess;
    logic [31:0] r_g [0:5];
    t_unr        w_p_unr;
    logic        w_p_vld;
    logic [31:0] w_p_bits;
    t_unr        w_d_unr;
    logic        w_d_vld;
    logic [31:0] w_d_bits;
    t_unr        w_r_unr;

    assign w_ce    = !(o_valid && i_stall);
    assign o_stall = !w_ce;
    assign w_guess = C_GUESS - i_divisor_bits;

    // guess travels alongside the first two operations
    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_g[0] <= w_guess;
            for (int i = 1; i < 6; i++) begin
                r_g[i] <= r_g[i-1];
            end
        end
    end

    rcp_fmul u_mul_xg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (w_ce),
        .i_valid (i_valid),
        .i_a     (i_divisor_bits),
        .i_b     (w_guess),
        .o_unr   (w_p_unr)
    );

    rcp_norm u_norm_p (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (w_ce),
        .i_unr   (w_p_unr),
        .o_valid (w_p_vld),
        .o_bits  (w_p_bits)
    );

    rcp_fsub u_sub (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (w_ce),
        .i_valid (w_p_vld),
        .i_p     (w_p_bits),
        .o_unr   (w_d_unr)
    );

    rcp_norm u_norm_d (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (w_ce),
        .i_unr   (w_d_unr),
        .o_valid (w_d_vld),
        .o_bits  (w_d_bits)
    );

    rcp_fmul u_mul_gd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (w_ce),
        .i_valid (w_d_vld),
        .i_a     (r_g[5]),
        .i_b     (w_d_bits),
        .o_unr   (w_r_unr)
    );

    rcp_norm u_norm_r (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (w_ce),
        .i_unr   (w_r_unr),
        .o_valid (o_valid),
        .o_bits  (o_reciprocal_bits)
    );

endmodule

>>> rtl/rcp_chk.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rcp_chk import rcp_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [31:0] o_reciprocal_bits
);

    logic w_held;
    logic w_nan_out;

    assign w_held    = o_valid && i_stall;
    assign w_nan_out = o_valid && (o_reciprocal_bits[30:23] == 8'hFF) &&
                       (o_reciprocal_bits[22:0] != 23'd0);

    // a result held back by the receiver stays put
    `RCP_ASSERT(a_out_hold, i_clk, i_rst_n, w_held |=> o_valid && $stable(o_reciprocal_bits))

    // back-pressure only comes from a stalled result
    `RCP_ASSERT(a_stall_src, i_clk, i_rst_n, o_stall |-> o_valid && i_stall)

    // any nan leaves in canonical form
    `RCP_ASSERT(a_nan_canon, i_clk, i_rst_n, w_nan_out |-> o_reciprocal_bits == C_QNAN)

    // pipeline comes out of reset empty
    `RCP_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !o_valid)

endmodule

bind float_reciprocal_approx_unit rcp_chk u_rcp_chk (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_stall           (o_stall),
    .o_valid           (o_valid),
    .i_stall           (i_stall),
    .o_reciprocal_bits (o_reciprocal_bits)
);
